[rtl/tprd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprd_pkg
// Shared types and constants of the touch panel receive deframer.
// ----------------------------------------------------------------------------
package tprd_pkg;

  // Byte values on the panel link.
  localparam logic [7:0] BYTE_TERM    = 8'hFF;
  localparam logic [7:0] LEAD_TOUCH   = 8'h67;
  localparam logic [7:0] LEAD_PAGE    = 8'h66;
  localparam logic [7:0] LEAD_RESTART = 8'h88;

  // Only the first bytes of a packet are ever decoded.
  localparam int KEEP_BYTES = 6;

  // Packet lengths of the recognized packets.
  localparam int LEN_TOUCH   = 6;
  localparam int LEN_PAGE    = 2;
  localparam int LEN_RESTART = 1;

  // Button rectangles in panel coordinates.
  localparam logic [15:0] BTN_LEFT_X0  = 16'd590;
  localparam logic [15:0] BTN_LEFT_X1  = 16'd683;
  localparam logic [15:0] BTN_RIGHT_X0 = 16'd690;
  localparam logic [15:0] BTN_RIGHT_X1 = 16'd783;
  localparam logic [15:0] TIME_BTN_Y0  = 16'd332;
  localparam logic [15:0] TIME_BTN_Y1  = 16'd381;
  localparam logic [15:0] SPEC_BTN_Y0  = 16'd316;
  localparam logic [15:0] SPEC_BTN_Y1  = 16'd365;

  // Configuration register indexes.
  localparam logic CFG_TIME_REFRESH = 1'b0;
  localparam logic CFG_SPEC_REFRESH = 1'b1;

  // Page codes.
  localparam logic PAGE_TIME = 1'b0;
  localparam logic PAGE_SPEC = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_TOUCH   = 2'd1,
    KIND_PAGE    = 2'd2,
    KIND_RESTART = 2'd3
  } pkt_kind_t;

  // Events the deframer hands to the controller for one item.
  typedef struct packed {
    logic        done;
    logic        dropped;
    pkt_kind_t   kind;
    logic [15:0] touch_x;
    logic [15:0] touch_y;
    logic        touch_press;
    logic        page_ok;
    logic        page_bit;
  } frame_ev_t;

  // One result item.
  typedef struct packed {
    logic        packet_done;
    logic [1:0]  packet_kind;
    logic        packet_dropped;
    logic        shown_page;
    logic        hold_active;
    logic [1:0]  periods_shown;
    logic        redraw_pending;
    logic        request_page_readback;
    logic        refresh_hold_indicator;
    logic        draw_now;
    logic [31:0] packets_received;
  } result_t;

endpackage

[rtl/tprd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprd_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tprd_item_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface tprd_result_if;
  logic        valid;
  logic        ready;
  logic        packet_done;
  logic [1:0]  packet_kind;
  logic        packet_dropped;
  logic        shown_page;
  logic        hold_active;
  logic [1:0]  periods_shown;
  logic        redraw_pending;
  logic        request_page_readback;
  logic        refresh_hold_indicator;
  logic        draw_now;
  logic [31:0] packets_received;

  modport source (
    output valid, output packet_done, output packet_kind, output packet_dropped,
    output shown_page, output hold_active, output periods_shown,
    output redraw_pending, output request_page_readback,
    output refresh_hold_indicator, output draw_now, output packets_received,
    input ready
  );
  modport sink (
    input valid, input packet_done, input packet_kind, input packet_dropped,
    input shown_page, input hold_active, input periods_shown,
    input redraw_pending, input request_page_readback,
    input refresh_hold_indicator, input draw_now, input packets_received,
    output ready
  );
endinterface

[rtl/tprd_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprd_deframer
// Collects panel bytes into packets ended by three 0xFF bytes and classifies
// a completed packet.
// ----------------------------------------------------------------------------
module tprd_deframer #(
  parameter int PACKET_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              req_type,
  input  logic [7:0]        rx_byte,
  output tprd_pkg::frame_ev_t ev
);
  import tprd_pkg::*;

  localparam int LW = $clog2(PACKET_BYTES + 1);

  logic [LW-1:0] len, len_next;
  logic [1:0]    run, run_next;
  logic [7:0]    pbyte [KEEP_BYTES];
  logic          slot_we    [KEEP_BYTES];
  logic [7:0]    slot_wdata [KEEP_BYTES];

  logic [LW:0]   len_ext, sum_ff, len_ff;
  logic          is_byte, is_term;

  always_comb begin
    is_byte = !req_type;
    is_term = (rx_byte == BYTE_TERM);
    len_ext = {1'b0, len};
    sum_ff  = len_ext + {{(LW - 1){1'b0}}, run};
    // Pending 0xFF bytes beyond the end of the buffer are lost.
    len_ff  = (sum_ff > (LW + 1)'(PACKET_BYTES)) ? (LW + 1)'(PACKET_BYTES) : sum_ff;

    ev             = '0;
    ev.touch_x     = {pbyte[1], pbyte[2]};
    ev.touch_y     = {pbyte[3], pbyte[4]};
    ev.touch_press = (pbyte[5] == 8'd0);
    ev.page_ok     = (pbyte[1][7:1] == 7'd0);
    ev.page_bit    = pbyte[1][0];

    len_next = len;
    run_next = run;
    for (int k = 0; k < KEEP_BYTES; k++) begin
      slot_we[k]    = 1'b0;
      slot_wdata[k] = rx_byte;
    end

    if (is_byte) begin
      if (is_term) begin
        if (run == 2'd2) begin
          ev.done  = 1'b1;
          len_next = '0;
          run_next = '0;
          if (len == LW'(LEN_TOUCH) && pbyte[0] == LEAD_TOUCH) begin
            ev.kind = KIND_TOUCH;
          end else if (len == LW'(LEN_PAGE) && pbyte[0] == LEAD_PAGE) begin
            ev.kind = KIND_PAGE;
          end else if (len == LW'(LEN_RESTART) && pbyte[0] == LEAD_RESTART) begin
            ev.kind = KIND_RESTART;
          end else begin
            ev.kind = KIND_NONE;
          end
        end else begin
          run_next = run + 2'd1;
        end
      end else begin
        // Flush the held 0xFF bytes as data, then place the byte itself.
        for (int k = 0; k < KEEP_BYTES; k++) begin
          if (run != 2'd0 && len_ext == (LW + 1)'(k)) begin
            slot_we[k]    = 1'b1;
            slot_wdata[k] = BYTE_TERM;
          end else if (run == 2'd2 && len_ext + (LW + 1)'(1) == (LW + 1)'(k)) begin
            slot_we[k]    = 1'b1;
            slot_wdata[k] = BYTE_TERM;
          end else if (len_ff == (LW + 1)'(k)) begin
            slot_we[k]    = 1'b1;
            slot_wdata[k] = rx_byte;
          end
        end
        run_next = '0;
        if (len_ff < (LW + 1)'(PACKET_BYTES)) begin
          len_next = LW'(len_ff + (LW + 1)'(1));
        end else begin
          len_next   = '0;
          ev.dropped = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      run <= '0;
    end else if (advance) begin
      len <= len_next;
      run <= run_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < KEEP_BYTES; k++) begin
      if (advance && slot_we[k]) begin
        pbyte[k] <= slot_wdata[k];
      end
    end
  end

endmodule

[rtl/tprd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprd_ctrl
// Page, hold and period state, touch buttons, refresh divider and packet
// counter; forms the result of each item.
// ----------------------------------------------------------------------------
module tprd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              tick,
  input  tprd_pkg::frame_ev_t ev,
  input  logic [7:0]        time_refresh,
  input  logic [7:0]        spec_refresh,
  output tprd_pkg::result_t res_next
);
  import tprd_pkg::*;

  logic        page, page_next;
  logic        hold, hold_next;
  logic [1:0]  period, period_next;
  logic        redraw, redraw_next;
  logic [7:0]  cnt, cnt_next;
  logic [31:0] counter, counter_next;

  logic        readback, hold_ind, draw;
  logic [7:0]  cnt_inc, refresh_sel;
  logic        x_left, x_right, y_time, y_spec;

  always_comb begin
    x_left  = ev.touch_x >= BTN_LEFT_X0  && ev.touch_x <= BTN_LEFT_X1;
    x_right = ev.touch_x >= BTN_RIGHT_X0 && ev.touch_x <= BTN_RIGHT_X1;
    y_time  = ev.touch_y >= TIME_BTN_Y0  && ev.touch_y <= TIME_BTN_Y1;
    y_spec  = ev.touch_y >= SPEC_BTN_Y0  && ev.touch_y <= SPEC_BTN_Y1;

    cnt_inc     = cnt + 8'd1;
    refresh_sel = (page == PAGE_TIME) ? time_refresh : spec_refresh;

    page_next    = page;
    hold_next    = hold;
    period_next  = period;
    redraw_next  = redraw;
    cnt_next     = cnt;
    counter_next = counter;
    readback     = 1'b0;
    hold_ind     = 1'b0;
    draw         = 1'b0;

    if (ev.done) begin
      counter_next = counter + 32'd1;
      case (ev.kind)
        KIND_TOUCH: begin
          if (ev.touch_press) begin
            readback = 1'b1;
            if (page == PAGE_TIME) begin
              if (x_left && y_time) begin
                page_next   = PAGE_SPEC;
                redraw_next = 1'b1;
                cnt_next    = '0;
              end else if (x_right && y_time) begin
                period_next = (period == 2'd1) ? 2'd3 : 2'd1;
                redraw_next = 1'b1;
                cnt_next    = '0;
              end
            end else begin
              if (x_left && y_spec) begin
                page_next   = PAGE_TIME;
                hold_next   = 1'b0;
                redraw_next = 1'b1;
                cnt_next    = '0;
              end else if (x_right && y_spec) begin
                hold_next = !hold;
                hold_ind  = 1'b1;
                // Releasing the hold repaints the page.
                if (hold) begin
                  redraw_next = 1'b1;
                  cnt_next    = '0;
                end
              end
            end
          end
        end
        KIND_PAGE: begin
          if (ev.page_ok) begin
            page_next = ev.page_bit;
            if (ev.page_bit == PAGE_TIME) begin
              hold_next = 1'b0;
            end
            redraw_next = 1'b1;
            cnt_next    = '0;
          end
        end
        KIND_RESTART: begin
          page_next   = PAGE_TIME;
          hold_next   = 1'b0;
          redraw_next = 1'b1;
          cnt_next    = '0;
        end
        default: begin
        end
      endcase
    end else if (tick && !(hold && page == PAGE_SPEC)) begin
      if (redraw || !(cnt_inc < refresh_sel)) begin
        cnt_next    = '0;
        redraw_next = 1'b0;
        draw        = 1'b1;
      end else begin
        cnt_next = cnt_inc;
      end
    end

    res_next.packet_done            = ev.done;
    res_next.packet_kind            = ev.done ? ev.kind : KIND_NONE;
    res_next.packet_dropped         = ev.dropped;
    res_next.shown_page             = page_next;
    res_next.hold_active            = hold_next;
    res_next.periods_shown          = period_next;
    res_next.redraw_pending         = redraw_next;
    res_next.request_page_readback  = readback;
    res_next.refresh_hold_indicator = hold_ind;
    res_next.draw_now               = draw;
    res_next.packets_received       = counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page    <= PAGE_TIME;
      hold    <= 1'b0;
      period  <= 2'd1;
      redraw  <= 1'b1;
      cnt     <= '0;
      counter <= '0;
    end else if (advance) begin
      page    <= page_next;
      hold    <= hold_next;
      period  <= period_next;
      redraw  <= redraw_next;
      cnt     <= cnt_next;
      counter <= counter_next;
    end
  end

endmodule

[rtl/touch_panel_rx_deframer_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_panel_rx_deframer_controller
// Receive deframer and touch controller for a serial display panel.
// ----------------------------------------------------------------------------
// Each input item is either a received panel byte or a measurement frame
// tick, and each produces exactly one result item. An accepted item is held
// in the input register; one pass of compare and update logic then advances
// the packet state and the display state and loads the result register
// once that register is empty or its content is being transferred out. The
// block takes one item per clock cycle while results are taken out as they
// appear; an item passes through the input register and then the result
// register before its result can be transferred out. The input side keeps
// accepting while a result waits, and stalls only when both registers are full and
// the waiting result is not being transferred out in that cycle.
// Packets end with three 0xFF bytes; shorter 0xFF runs followed by another
// byte are kept as data. Only the first six bytes of a packet are stored,
// since no recognized packet is longer; the length counter still runs to
// PACKET_BYTES so that overflow drops the packet as specified. The two
// refresh registers are written through the cfg port and must only change
// while no item is in flight.
// ----------------------------------------------------------------------------
module touch_panel_rx_deframer_controller #(
  parameter int PACKET_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  tprd_item_if.sink    item,
  tprd_result_if.source result
);
  import tprd_pkg::*;

  // Refresh divider registers.
  logic [7:0] time_refresh;
  logic [7:0] spec_refresh;

  // Input register stage.
  logic       in_valid;
  logic       in_req_type;
  logic [7:0] in_rx_byte;

  // Result register stage.
  logic       out_valid;
  result_t    res;
  result_t    res_next;

  frame_ev_t  ev;
  logic       advance;

  // The held item moves to the result register whenever that register is
  // empty or its content is being transferred out in this cycle.
  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_refresh <= 8'd20;
      spec_refresh <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIME_REFRESH: time_refresh <= cfg_data;
        CFG_SPEC_REFRESH: spec_refresh <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_req_type <= item.req_type;
      in_rx_byte  <= item.rx_byte;
    end
  end

  tprd_deframer #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_deframer (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .req_type (in_req_type),
    .rx_byte  (in_rx_byte),
    .ev       (ev)
  );

  tprd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .tick         (in_req_type),
    .ev           (ev),
    .time_refresh (time_refresh),
    .spec_refresh (spec_refresh),
    .res_next     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign result.valid                  = out_valid;
  assign result.packet_done            = res.packet_done;
  assign result.packet_kind            = res.packet_kind;
  assign result.packet_dropped         = res.packet_dropped;
  assign result.shown_page             = res.shown_page;
  assign result.hold_active            = res.hold_active;
  assign result.periods_shown          = res.periods_shown;
  assign result.redraw_pending         = res.redraw_pending;
  assign result.request_page_readback  = res.request_page_readback;
  assign result.refresh_hold_indicator = res.refresh_hold_indicator;
  assign result.draw_now               = res.draw_now;
  assign result.packets_received       = res.packets_received;

endmodule
